@@ design/c3zf_pkg.sv @@
// Shared types and constants of the 3x3 zero-border convolution filter.
package c3zf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int TAPS      = 3;
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int KROW_W       = TAPS * COEF_W;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_INDEX_W  = 3;

  // Unsigned pixel with a zero sign bit times a signed coefficient.
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int ROW_SUM_W = PROD_W + 2;
  localparam int ACC_W     = PROD_W + 4;
  localparam int Q_W       = ACC_W - FRAC_BITS;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = 13'd512;
  // Every tap 1820/16384, close to one ninth.
  localparam logic [KROW_W-1:0]       KERNEL_ROW_RST   = 48'h071C_071C_071C;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             clipped;
    logic             frame_end;
  } out_word_t;

  // Border masks and frame-end mark that travel with one output position.
  typedef struct packed {
    logic last;
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
  } tap_ctl_t;

endpackage

@@ design/c3zf_mac.sv @@
// Masked 3x3 multiply-accumulate with truncation and byte saturation.
module c3zf_mac (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  logic                                                    in_emit,
  input  c3zf_pkg::tap_ctl_t                                      ctl,
  input  logic [c3zf_pkg::TAPS*c3zf_pkg::TAPS-1:0][c3zf_pkg::PIX_W-1:0] win,
  input  logic [c3zf_pkg::TAPS-1:0][c3zf_pkg::KROW_W-1:0]         kernel,
  output logic                                                    out_valid,
  output c3zf_pkg::out_word_t                                     out_word
);

  localparam int TAPS      = c3zf_pkg::TAPS;
  localparam int NTAP      = TAPS * TAPS;
  localparam int PIX_W     = c3zf_pkg::PIX_W;
  localparam int COEF_W    = c3zf_pkg::COEF_W;
  localparam int PROD_W    = c3zf_pkg::PROD_W;
  localparam int ROW_SUM_W = c3zf_pkg::ROW_SUM_W;
  localparam int ACC_W     = c3zf_pkg::ACC_W;
  localparam int Q_W       = c3zf_pkg::Q_W;
  localparam int FRAC_BITS = c3zf_pkg::FRAC_BITS;

  logic [TAPS-1:0]                 row_ok;
  logic [TAPS-1:0]                 col_ok;
  logic signed [PROD_W-1:0]        pix_ext  [NTAP];
  logic signed [PROD_W-1:0]        coef_ext [NTAP];
  logic signed [PROD_W-1:0]        prod_next [NTAP];

  logic signed [PROD_W-1:0]        p_prod [NTAP];
  logic                            p_valid;
  logic                            p_last;

  logic signed [ROW_SUM_W-1:0]     r_sum [TAPS];
  logic                            r_valid;
  logic                            r_last;

  logic signed [ACC_W-1:0]         total;
  logic signed [Q_W-1:0]           q_floor;
  logic signed [Q_W-1:0]           q;
  logic                            round_up;
  c3zf_pkg::out_word_t             result;

  assign row_ok = {ctl.bottom_ok, 1'b1, ctl.top_ok};
  assign col_ok = {ctl.right_ok, 1'b1, ctl.left_ok};

  // Taps outside the frame contribute nothing.
  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS; c++) begin
        pix_ext[r*TAPS+c]  = PROD_W'(signed'({1'b0, win[r*TAPS+c]}));
        coef_ext[r*TAPS+c] = PROD_W'(signed'(kernel[r][c*COEF_W +: COEF_W]));
        if (row_ok[r] && col_ok[c]) begin
          prod_next[r*TAPS+c] = pix_ext[r*TAPS+c] * coef_ext[r*TAPS+c];
        end else begin
          prod_next[r*TAPS+c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NTAP; i++) begin
        p_prod[i] <= prod_next[i];
      end
      p_last <= ctl.last;
      for (int r = 0; r < TAPS; r++) begin
        r_sum[r] <= ROW_SUM_W'(p_prod[r*TAPS]) + ROW_SUM_W'(p_prod[r*TAPS+1])
                  + ROW_SUM_W'(p_prod[r*TAPS+2]);
      end
      r_last   <= p_last;
      out_word <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_emit;
      r_valid   <= p_valid;
      out_valid <= r_valid;
    end
  end

  // Division by 2^14 rounds toward zero: a negative sum with a nonzero
  // fraction moves up by one after the arithmetic shift.
  always_comb begin
    total    = ACC_W'(r_sum[0]) + ACC_W'(r_sum[1]) + ACC_W'(r_sum[2]);
    q_floor  = signed'(total[ACC_W-1:FRAC_BITS]);
    round_up = total[ACC_W-1] && (total[FRAC_BITS-1:0] != '0);
    q        = q_floor + Q_W'(round_up);
    result.frame_end = r_last;
    if (q[Q_W-1]) begin
      result.pixel_out = '0;
      result.clipped   = 1'b1;
    end else if (q[Q_W-2:PIX_W] != '0) begin
      result.pixel_out = '1;
      result.clipped   = 1'b1;
    end else begin
      result.pixel_out = q[PIX_W-1:0];
      result.clipped   = 1'b0;
    end
  end

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.clipped) |->
      (out_word.pixel_out == '0 || out_word.pixel_out == '1))
    else $error("clipped word is not at a rail");

endmodule

@@ design/conv3x3_zero_border_filter.sv @@
// A word leaves once the input word that releases it has passed the memory stage,
// window, products, row sums and output register; that input word is frame_width+1 words after its own pixel.
// Throughput: one word per cycle while the output is not stalled; the line memory does one read-modify-write
// per word, with forwarding when a row is one pixel wide.
// Reset (synchronous): counters, window and registers return to defaults;
// the line memory is not cleared.
module conv3x3_zero_border_filter #(
  parameter int MAX_WIDTH  = c3zf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3zf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  c3zf_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output c3zf_pkg::out_word_t                 out_word,
  input  logic                                cfg_write,
  input  logic [c3zf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [c3zf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TAPS   = c3zf_pkg::TAPS;
  localparam int PIX_W  = c3zf_pkg::PIX_W;
  localparam int KROW_W = c3zf_pkg::KROW_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  // The input row runs up to one past the frame height while draining.
  localparam int IROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int OROW_W = HDIM_W;
  localparam int LINE_W = 2 * PIX_W;

  logic [c3zf_pkg::WIDTH_REG_W-1:0]  frame_width;
  logic [c3zf_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [TAPS-1:0][KROW_W-1:0]       kernel_rows;

  logic [WDIM_W-1:0] w;
  logic [HDIM_W-1:0] h;

  logic [IROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]  in_col, in_col_next;
  logic [OROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0]  out_col, out_col_next;

  logic              adv;
  logic              take;
  logic              enter;
  logic              receiving;
  logic              emit_now;
  logic              last_now;
  logic [PIX_W-1:0]  val_now;
  logic [31:0]       col_inc;
  logic [31:0]       ocol_inc;
  c3zf_pkg::tap_ctl_t ctl_now;

  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] fwd_data;
  logic              fwd_hit;
  logic [LINE_W-1:0] s1_line;
  logic [PIX_W-1:0]  s1_top;
  logic [PIX_W-1:0]  s1_mid;

  logic               s1_valid;
  logic               s1_emit;
  logic [PIX_W-1:0]   s1_val;
  logic [COL_W-1:0]   s1_addr;
  c3zf_pkg::tap_ctl_t s1_ctl;

  logic [TAPS*TAPS-1:0][PIX_W-1:0] win;
  logic                            s2_emit;
  c3zf_pkg::tap_ctl_t              s2_ctl;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= c3zf_pkg::FRAME_WIDTH_RST;
      frame_height <= c3zf_pkg::FRAME_HEIGHT_RST;
      for (int r = 0; r < TAPS; r++) begin
        kernel_rows[r] <= c3zf_pkg::KERNEL_ROW_RST;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        c3zf_pkg::REG_FRAME_WIDTH:   frame_width    <= cfg_data[c3zf_pkg::WIDTH_REG_W-1:0];
        c3zf_pkg::REG_FRAME_HEIGHT:  frame_height   <= cfg_data[c3zf_pkg::HEIGHT_REG_W-1:0];
        c3zf_pkg::REG_KERNEL_TOP:    kernel_rows[0] <= cfg_data[KROW_W-1:0];
        c3zf_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] <= cfg_data[KROW_W-1:0];
        c3zf_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] <= cfg_data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w = WDIM_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w = WDIM_W'(MAX_WIDTH);
    end else begin
      w = WDIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      h = HDIM_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h = HDIM_W'(MAX_HEIGHT);
    end else begin
      h = HDIM_W'(frame_height);
    end
  end

  // The whole pipeline moves together; it only halts on a held output word.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign take     = in_valid && !in_stall;

  // A flush tick during the frame is taken and dropped.
  assign receiving = 32'(in_row) < 32'(h);
  assign enter     = take && !(in_word.mode && receiving);
  assign val_now   = (receiving && !in_word.mode) ? in_word.pixel_in : '0;
  assign emit_now  = (32'(in_row) >= 32'd2) || (32'(in_row) == 32'd1 && in_col != '0);
  assign col_inc   = 32'(in_col) + 32'd1;
  assign ocol_inc  = 32'(out_col) + 32'd1;
  assign last_now  = emit_now && (32'(out_row) + 32'd1 >= 32'(h)) && (ocol_inc >= 32'(w));

  assign ctl_now.last      = last_now;
  assign ctl_now.top_ok    = out_row != '0;
  assign ctl_now.bottom_ok = 32'(out_row) + 32'd1 < 32'(h);
  assign ctl_now.left_ok   = out_col != '0;
  assign ctl_now.right_ok  = ocol_inc < 32'(w);

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (enter) begin
      if (col_inc >= 32'(w)) begin
        in_col_next = '0;
        in_row_next = IROW_W'(32'(in_row) + 32'd1);
      end else begin
        in_col_next = COL_W'(col_inc);
      end
      if (last_now) begin
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (emit_now) begin
        if (ocol_inc >= 32'(w)) begin
          out_col_next = '0;
          out_row_next = OROW_W'(32'(out_row) + 32'd1);
        end else begin
          out_col_next = COL_W'(ocol_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // Line memory: each entry holds the two rows above, upper in the high byte.
  // When the row is one pixel wide the next word reads the entry that is
  // being written back, so that write is forwarded.
  assign s1_line = fwd_hit ? fwd_data : line_rdata;
  assign s1_top  = s1_line[LINE_W-1:PIX_W];
  assign s1_mid  = s1_line[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (enter) begin
      line_rdata <= line_mem[in_col];
      fwd_hit    <= s1_valid && (s1_addr == in_col);
      fwd_data   <= {s1_mid, s1_val};
      s1_val     <= val_now;
      s1_addr    <= in_col;
      s1_emit    <= emit_now;
      s1_ctl     <= ctl_now;
    end
    if (adv && s1_valid) begin
      line_mem[s1_addr] <= {s1_mid, s1_val};
      s2_ctl            <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_emit  <= 1'b0;
      win      <= '0;
    end else if (adv) begin
      s1_valid <= enter;
      s2_emit  <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int r = 0; r < TAPS; r++) begin
          for (int c = 0; c < TAPS - 1; c++) begin
            win[r*TAPS+c] <= win[r*TAPS+c+1];
          end
        end
        win[TAPS-1]          <= s1_top;
        win[2*TAPS-1]        <= s1_mid;
        win[TAPS*TAPS-1]     <= s1_val;
      end
    end
  end

  c3zf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_emit   (s2_emit),
    .ctl       (s2_ctl),
    .win       (win),
    .kernel    (kernel_rows),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (enter && last_now) |=>
      (in_row == '0 && in_col == '0 && out_row == '0 && out_col == '0))
    else $error("counters not cleared after the last output of a frame");

  a_early_flush: assert property (@(posedge clk) disable iff (rst)
    (take && in_word.mode && receiving) |=>
      ($stable(in_row) && $stable(in_col) && $stable(out_row) && $stable(out_col)))
    else $error("flush during the frame moved the position counters");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_addr) && $stable(s1_val)))
    else $error("memory stage changed while the pipeline was held");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv && s1_valid) |=> $stable(win))
    else $error("window moved without a word leaving the memory stage");

endmodule
